FILE: rtl/core/lbp_pkg.sv
// Package with constants, types and the arctangent table for the lidar point converter.
package lbp_pkg;

  localparam int MaxBeamsDef   = 128;
  localparam int TrigStagesDef = 16;
  localparam int CfgIdxW       = 3;
  localparam int CfgDataW      = 24;

  localparam logic [CfgIdxW-1:0] RegRangeMin = 3'd0;
  localparam logic [CfgIdxW-1:0] RegRangeMax = 3'd1;
  localparam logic [CfgIdxW-1:0] RegElevMin  = 3'd2;
  localparam logic [CfgIdxW-1:0] RegElevStep = 3'd3;
  localparam logic [CfgIdxW-1:0] RegBeamCnt  = 3'd4;
  localparam logic [CfgIdxW-1:0] RegLegacy   = 3'd5;

  localparam logic signed [35:0] CordicGain = 36'sd652032874;

  typedef logic signed [35:0] cval_t;

  // Payload that travels along the chain beside the two rotators.
  typedef struct packed {
    logic        vld;
    logic [23:0] range;
    logic [15:0] inten;
    logic [6:0]  ring;
    logic [15:0] rot;
    logic        legacy;
  } side_t;

  // One CORDIC rotator state.
  typedef struct packed {
    cval_t       x;
    cval_t       y;
    logic signed [33:0] z;
    logic [1:0]  q;
  } rot_t;

  function automatic logic [31:0] atan_val(input int i);
    logic [31:0] t;
    begin
      case (i)
        0: t = 32'h20000000;  1: t = 32'h12E4051E;  2: t = 32'h09FB385B;
        3: t = 32'h051111D4;  4: t = 32'h028B0D43;  5: t = 32'h0145D7E1;
        6: t = 32'h00A2F61E;  7: t = 32'h00517C55;  8: t = 32'h0028BE53;
        9: t = 32'h00145F2F;  10: t = 32'h000A2F98; 11: t = 32'h000517CC;
        12: t = 32'h00028BE6; 13: t = 32'h000145F3; 14: t = 32'h0000A2FA;
        15: t = 32'h0000517D; 16: t = 32'h000028BE; 17: t = 32'h0000145F;
        18: t = 32'h00000A30; 19: t = 32'h00000518; 20: t = 32'h0000028C;
        21: t = 32'h00000146; 22: t = 32'h000000A3; 23: t = 32'h00000051;
        default: t = 32'h0;
      endcase
      return t;
    end
  endfunction

  // Splits a 32 bit phase into quadrant and signed residual, seeds the rotator.
  function automatic rot_t rot_seed(input logic [31:0] phase);
    rot_t o;
    logic [1:0] q;
    logic [31:0] d;
    begin
      q = 2'((phase + 32'h20000000) >> 30);
      d = phase - {q, 30'd0};
      o.x = CordicGain;
      o.y = '0;
      o.z = 34'(signed'(d));
      o.q = q;
      return o;
    end
  endfunction

  function automatic logic signed [24:0] sat25(input logic signed [47:0] v);
    begin
      if (v > 48'sd16777215) return 25'sd16777215;
      if (v < -48'sd16777216) return -25'sd16777216;
      return v[24:0];
    end
  endfunction

endpackage

FILE: rtl/core/lbp_cell.sv
// One CORDIC cell: rotates both angle vectors by one table step and passes the beam along.
module lbp_cell import lbp_pkg::*; #(
  parameter int Step = 0
) (
  input  logic  clk,
  input  logic  rst_n,
  input  side_t side_i,
  input  rot_t  ev_i,
  input  rot_t  rv_i,
  output side_t side_o,
  output rot_t  ev_o,
  output rot_t  rv_o
);

  side_t side_r;
  rot_t  ev_r, rv_r;
  rot_t  ev_nxt, rv_nxt;

  function automatic rot_t rot_step(input rot_t a);
    rot_t o;
    cval_t xs, ys;
    logic signed [33:0] at;
    begin
      xs = a.x >>> Step;
      ys = a.y >>> Step;
      at = 34'(atan_val(Step));
      o = a;
      if (!a.z[33]) begin
        o.x = a.x - ys; o.y = a.y + xs; o.z = a.z - at;
      end else begin
        o.x = a.x + ys; o.y = a.y - xs; o.z = a.z + at;
      end
      return o;
    end
  endfunction

  always_comb begin
    ev_nxt = rot_step(ev_i);
    rv_nxt = rot_step(rv_i);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_r.vld <= 1'b0;
    end else begin
      side_r.vld <= side_i.vld;
    end
    side_r.range  <= side_i.range;
    side_r.inten  <= side_i.inten;
    side_r.ring   <= side_i.ring;
    side_r.rot    <= side_i.rot;
    side_r.legacy <= side_i.legacy;
    ev_r <= ev_nxt;
    rv_r <= rv_nxt;
  end

  assign side_o = side_r;
  assign ev_o   = ev_r;
  assign rv_o   = rv_r;

endmodule

FILE: rtl/core/lbp_scale.sv
// Output stages: quadrant fold, range scaling, rounding and saturation.
module lbp_scale import lbp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  side_t       side_i,
  input  rot_t        ev_i,
  input  rot_t        rv_i,
  output logic        done,
  output logic signed [24:0] x_mm,
  output logic signed [24:0] y_mm,
  output logic signed [24:0] z_mm,
  output logic [15:0] intensity_out,
  output logic [6:0]  ring,
  output logic signed [15:0] rotation_wrapped
);

  function automatic logic signed [35:0] fold_c(input rot_t a);
    begin
      case (a.q)
        2'd0: return a.x;
        2'd1: return -a.y;
        2'd2: return -a.x;
        default: return a.y;
      endcase
    end
  endfunction

  function automatic logic signed [35:0] fold_s(input rot_t a);
    begin
      case (a.q)
        2'd0: return a.y;
        2'd1: return a.x;
        2'd2: return -a.y;
        default: return -a.x;
      endcase
    end
  endfunction

  side_t s1_r, s2_r, s3_r;
  logic signed [35:0] cv1_r, sv1_r, cr1_r, sr1_r, cr2_r, sr2_r;
  logic signed [35:0] t2_r;
  logic signed [47:0] z2_r;
  logic signed [47:0] x3_r, y3_r, z3_r;
  logic signed [61:0] rc, rs;
  logic signed [71:0] px, py;
  logic signed [47:0] t_nxt, z_nxt, x_nxt, y_nxt;

  always_comb begin
    rc = $signed({38'd0, s1_r.range}) * cv1_r;
    rs = $signed({38'd0, s1_r.range}) * sv1_r;
    t_nxt = 48'((rc + 62'sd2097152) >>> 22);
    z_nxt = 48'((rs + 62'sd536870912) >>> 30);
    if (s1_r.legacy) z_nxt = -z_nxt;
    px = t2_r * cr2_r;
    py = t2_r * sr2_r;
    x_nxt = 48'((px + 72'sh2000000000) >>> 38);
    y_nxt = 48'((py + 72'sh2000000000) >>> 38);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r.vld <= 1'b0; s2_r.vld <= 1'b0; s3_r.vld <= 1'b0;
    end else begin
      s1_r.vld <= side_i.vld; s2_r.vld <= s1_r.vld; s3_r.vld <= s2_r.vld;
    end
    {s1_r.range, s1_r.inten, s1_r.ring, s1_r.rot, s1_r.legacy} <=
      {side_i.range, side_i.inten, side_i.ring, side_i.rot, side_i.legacy};
    {s2_r.range, s2_r.inten, s2_r.ring, s2_r.rot, s2_r.legacy} <=
      {s1_r.range, s1_r.inten, s1_r.ring, s1_r.rot, s1_r.legacy};
    {s3_r.range, s3_r.inten, s3_r.ring, s3_r.rot, s3_r.legacy} <=
      {s2_r.range, s2_r.inten, s2_r.ring, s2_r.rot, s2_r.legacy};
    cv1_r <= fold_c(ev_i);
    sv1_r <= fold_s(ev_i);
    cr1_r <= fold_c(rv_i);
    sr1_r <= fold_s(rv_i);
    cr2_r <= cr1_r;
    sr2_r <= sr1_r;
    t2_r  <= 36'(t_nxt);
    z2_r  <= z_nxt;
    x3_r  <= x_nxt;
    y3_r  <= y_nxt;
    z3_r  <= z2_r;
  end

  assign done             = s3_r.vld;
  assign x_mm             = sat25(x3_r);
  assign y_mm             = sat25(y3_r);
  assign z_mm             = sat25(z3_r);
  assign intensity_out    = s3_r.inten;
  assign ring             = s3_r.ring;
  assign rotation_wrapped = s3_r.rot;

endmodule

FILE: rtl/core/lidar_beam_to_point.sv
// Top level of the lidar beam to Cartesian point converter.
// Path from start to out_valid: the registered CORDIC cell chain, then the output stages of lbp_scale.
// Throughput: one beam per cycle; the CORDIC cell chain is fully pipelined.
// Beams outside the range gate or beam count travel as bubbles and give no strobe.
// Synchronous active-low reset clears the configuration registers to their defaults and drops all strobes.
module lidar_beam_to_point import lbp_pkg::*; #(
  parameter int MAX_BEAMS   = MaxBeamsDef,
  parameter int TRIG_STAGES = TrigStagesDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [23:0] in_range_mm,
  input  logic [15:0] in_intensity_in,
  input  logic [6:0]  in_beam_index,
  input  logic signed [31:0] in_turn_angle,
  output logic        out_valid,
  output logic signed [24:0] out_x_mm,
  output logic signed [24:0] out_y_mm,
  output logic signed [24:0] out_z_mm,
  output logic [15:0] out_intensity_out,
  output logic [6:0]  out_ring,
  output logic signed [15:0] out_rotation_wrapped,
  input  logic        cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data
);

  localparam int CntW = $clog2(MAX_BEAMS + 1);

  logic [23:0] range_min_r, range_max_r;
  logic [15:0] elev_min_r;
  logic [22:0] elev_step_r;
  logic [7:0]  beam_cnt_r;
  logic        legacy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      range_min_r <= '0;
      range_max_r <= 24'hFFFFFF;
      elev_min_r  <= '0;
      elev_step_r <= '0;
      beam_cnt_r  <= 8'd1;
      legacy_r    <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        RegRangeMin: range_min_r <= cfg_data;
        RegRangeMax: range_max_r <= cfg_data;
        RegElevMin:  elev_min_r  <= cfg_data[15:0];
        RegElevStep: elev_step_r <= cfg_data[22:0];
        RegBeamCnt:  beam_cnt_r  <= cfg_data[7:0];
        RegLegacy:   legacy_r    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  logic [CntW-1:0] count;
  logic [31:0] cnt32, idx32;
  logic [23:0] elev;
  logic [29:0] prod;
  side_t side0;
  rot_t  ev0, rv0;

  always_comb begin
    if (32'(beam_cnt_r) > 32'(MAX_BEAMS)) count = CntW'(MAX_BEAMS);
    else count = CntW'(beam_cnt_r);
    cnt32 = 32'(count);
    idx32 = 32'(in_beam_index);
    prod  = 30'(in_beam_index) * 30'(elev_step_r);
    if (cnt32 == 32'd1) elev = {elev_min_r, 8'd0};
    else elev = {elev_min_r, 8'd0} + prod[23:0];
    side0.vld    = start && (in_range_mm > range_min_r) && (in_range_mm < range_max_r)
                   && (idx32 < cnt32);
    side0.range  = in_range_mm;
    side0.inten  = in_intensity_in;
    side0.ring   = legacy_r ? 7'(cnt32 - 32'd1 - idx32) : in_beam_index;
    side0.rot    = in_turn_angle[15:0];
    side0.legacy = legacy_r;
    ev0 = rot_seed({elev, 8'd0});
    rv0 = rot_seed({in_turn_angle[15:0], 16'd0});
  end

  side_t side_c [TRIG_STAGES+1];
  rot_t  ev_c   [TRIG_STAGES+1];
  rot_t  rv_c   [TRIG_STAGES+1];

  assign side_c[0] = side0;
  assign ev_c[0]   = ev0;
  assign rv_c[0]   = rv0;

  for (genvar g = 0; g < TRIG_STAGES; g++) begin : g_cell
    lbp_cell #(.Step(g)) u_cell (
      .clk(clk), .rst_n(rst_n),
      .side_i(side_c[g]), .ev_i(ev_c[g]), .rv_i(rv_c[g]),
      .side_o(side_c[g+1]), .ev_o(ev_c[g+1]), .rv_o(rv_c[g+1])
    );
  end

  lbp_scale u_scale (
    .clk(clk), .rst_n(rst_n),
    .side_i(side_c[TRIG_STAGES]), .ev_i(ev_c[TRIG_STAGES]), .rv_i(rv_c[TRIG_STAGES]),
    .done(out_valid),
    .x_mm(out_x_mm), .y_mm(out_y_mm), .z_mm(out_z_mm),
    .intensity_out(out_intensity_out), .ring(out_ring),
    .rotation_wrapped(out_rotation_wrapped)
  );

  assign busy = 1'b0;

`ifndef SYNTHESIS
  a_no_valid_after_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("strobe right after reset");
  a_gate_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (start && in_range_mm <= range_min_r) |=> !side_c[1].vld)
    else $error("gated beam entered chain");
  a_ring_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (32'(out_ring) < 32'(MAX_BEAMS)))
    else $error("ring out of range");
`endif

endmodule

FILE: verif/lidar_beam_to_point_checker.sv
// Checker for the lidar point converter: predicts each point and compares the output words.
`timescale 1ns / 100ps

module lidar_beam_to_point_checker import lbp_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               busy,
  input  logic [23:0]        in_range_mm,
  input  logic [15:0]        in_intensity_in,
  input  logic [6:0]         in_beam_index,
  input  logic signed [31:0] in_turn_angle,
  input  logic               out_valid,
  input  logic signed [24:0] out_x_mm,
  input  logic signed [24:0] out_y_mm,
  input  logic signed [24:0] out_z_mm,
  input  logic [15:0]        out_intensity_out,
  input  logic [6:0]         out_ring,
  input  logic signed [15:0] out_rotation_wrapped,
  input  logic               cfg_we,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [CfgDataW-1:0] cfg_data,
  output int                 errors,
  output int                 pending
);

  typedef struct packed {
    logic [24:0] x;
    logic [24:0] y;
    logic [24:0] z;
    logic [15:0] inten;
    logic [6:0]  ring;
    logic [15:0] rot;
  } point_t;

  localparam logic [31:0] ArcTab [24] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  logic [23:0] gate_lo, gate_hi, elev_step;
  logic [15:0] elev_base;
  logic [7:0]  beams;
  logic        legacy;
  point_t      points_due[$];

  function automatic void sin_cos(input logic [31:0] phase, output longint c,
                                  output longint s);
    logic [31:0] quad, resid;
    longint x, y, z, xs, ys;
    begin
      quad = ((phase + 32'h20000000) >> 30) & 32'd3;
      resid = phase - (quad << 30);
      z = longint'(signed'(resid));
      x = 652032874;
      y = 0;
      for (int i = 0; i < TrigStagesDef && i < 24; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (z >= 0) begin
          x = x - ys; y = y + xs; z = z - longint'(ArcTab[i]);
        end else begin
          x = x + ys; y = y - xs; z = z + longint'(ArcTab[i]);
        end
      end
      case (quad[1:0])
        2'd0: begin c = x;  s = y;  end
        2'd1: begin c = -y; s = x;  end
        2'd2: begin c = -x; s = -y; end
        default: begin c = y; s = -x; end
      endcase
    end
  endfunction

  function automatic logic [24:0] clamp25(input longint v);
    begin
      if (v > 16777215) return 25'h0FFFFFF;
      if (v < -16777216) return 25'h1000000;
      return v[24:0];
    end
  endfunction

  function automatic bit beam_to_point(input logic [23:0] r, input logic [15:0] inten,
                                       input logic [6:0] idx, input logic [31:0] ang,
                                       output point_t p);
    logic [7:0]  cnt;
    logic [31:0] elev_sum;
    logic [23:0] elev;
    longint cv, sv, cr, sr, t, x, y, z, rl;
    begin
      cnt = (beams > 8'd128) ? 8'd128 : beams;
      if (r <= gate_lo || r >= gate_hi || {1'b0, idx} >= cnt) return 0;
      elev_sum = {8'd0, elev_base, 8'd0};
      if (cnt != 8'd1) elev_sum = elev_sum + idx * {9'd0, elev_step[22:0]};
      elev = elev_sum[23:0];
      sin_cos({elev, 8'd0}, cv, sv);
      sin_cos({ang[15:0], 16'd0}, cr, sr);
      rl = longint'({40'd0, r});
      t = (rl * cv + (longint'(1) <<< 21)) >>> 22;
      x = (t * cr + (longint'(1) <<< 37)) >>> 38;
      y = (t * sr + (longint'(1) <<< 37)) >>> 38;
      z = (rl * sv + (longint'(1) <<< 29)) >>> 30;
      if (legacy) z = -z;
      p.x = clamp25(x);
      p.y = clamp25(y);
      p.z = clamp25(z);
      p.inten = inten;
      p.ring = legacy ? 7'(cnt - 8'd1 - {1'b0, idx}) : idx;
      p.rot = ang[15:0];
      return 1;
    end
  endfunction

  assign pending = points_due.size();

  always @(posedge clk) begin
    point_t want, got;
    if (!rst_n) begin
      gate_lo = '0;
      gate_hi = 24'hFFFFFF;
      elev_base = '0;
      elev_step = '0;
      beams = 8'd1;
      legacy = 1'b0;
      points_due.delete();
      errors = 0;
    end else begin
      if (out_valid) begin
        got = '{out_x_mm, out_y_mm, out_z_mm, out_intensity_out, out_ring,
                out_rotation_wrapped};
        if (points_due.size() == 0) begin
          errors++;
          if (errors <= 10) $display("%0t: unexpected point word %h", $realtime, got);
        end else begin
          want = points_due.pop_front();
          if (want != got) begin
            errors++;
            if (errors <= 10)
              $display("%0t: point mismatch x %0d/%0d y %0d/%0d z %0d/%0d int %h/%h ring %0d/%0d rot %h/%h (expected/actual)",
                       $realtime, signed'(want.x), out_x_mm, signed'(want.y), out_y_mm,
                       signed'(want.z), out_z_mm, want.inten, out_intensity_out,
                       want.ring, out_ring, want.rot, out_rotation_wrapped);
          end
        end
      end
      if (start && !busy && beam_to_point(in_range_mm, in_intensity_in, in_beam_index,
                                          in_turn_angle, want))
        points_due.push_back(want);
      if (cfg_we) begin
        case (cfg_index)
          RegRangeMin: gate_lo = cfg_data;
          RegRangeMax: gate_hi = cfg_data;
          RegElevMin:  elev_base = cfg_data[15:0];
          RegElevStep: elev_step = {1'b0, cfg_data[22:0]};
          RegBeamCnt:  beams = cfg_data[7:0];
          RegLegacy:   legacy = cfg_data[0];
          default: ;
        endcase
      end
    end
  end

endmodule

FILE: verif/lidar_beam_to_point_test.sv
// Top of the lidar point converter testbench: clock, reset, beam stimulus and verdict.
`timescale 1ns / 100ps

module lidar_beam_to_point_test import lbp_pkg::*; ();

  localparam logic [CfgIdxW-1:0] RegSpare = 3'd7;
  localparam int Settle = TrigStagesDef + 12;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [23:0] in_range_mm = '0;
  logic [15:0] in_intensity_in = '0;
  logic [6:0] in_beam_index = '0;
  logic signed [31:0] in_turn_angle = '0;
  logic out_valid;
  logic signed [24:0] out_x_mm, out_y_mm, out_z_mm;
  logic [15:0] out_intensity_out;
  logic [6:0] out_ring;
  logic signed [15:0] out_rotation_wrapped;
  logic cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;
  int errors, pending;
  logic [23:0] gate_lo, gate_hi;
  int beams_used;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  lidar_beam_to_point DUT (.*);

  lidar_beam_to_point_checker checker_i (.*);

  task automatic send_beam(input logic [23:0] r, input logic [15:0] inten,
                           input logic [6:0] idx, input logic [31:0] ang);
    int pick, gap;
    begin
      in_range_mm = r;
      in_intensity_in = inten;
      in_beam_index = idx;
      in_turn_angle = ang;
      start = 1'b1;
      do @(posedge clk); while (busy);
      @(negedge clk);
      pick = $urandom_range(0, 99);
      gap = (pick < 65) ? 0 : (pick < 95) ? $urandom_range(1, 3) : $urandom_range(8, 40);
      if (gap > 0) begin
        start = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
  endtask

  task automatic drain();
    begin
      start = 1'b0;
      while (pending != 0) @(negedge clk);
      repeat (Settle) @(negedge clk);
    end
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    begin
      cfg_we = 1'b1;
      cfg_index = idx;
      cfg_data = val;
      @(negedge clk);
      cfg_we = 1'b0;
    end
  endtask

  task automatic set_mode(input logic [23:0] lo, input logic [23:0] hi,
                          input logic [15:0] emin, input logic [22:0] estep,
                          input logic [7:0] nbeams, input logic leg);
    begin
      drain();
      write_reg(RegRangeMin, lo);
      write_reg(RegRangeMax, hi);
      write_reg(RegElevMin, {8'($urandom_range(0, 255)), emin});
      write_reg(RegElevStep, {1'($urandom_range(0, 1)), estep});
      write_reg(RegBeamCnt, {16'($urandom_range(0, 65535)), nbeams});
      write_reg(RegLegacy, {23'($urandom_range(0, 8388607)), leg});
      write_reg(RegSpare, 24'($urandom));
      gate_lo = lo;
      gate_hi = hi;
      beams_used = (nbeams > 8'd128) ? 128 : int'(nbeams);
    end
  endtask

  task automatic random_beams(input int count);
    logic [23:0] r;
    logic [6:0] idx;
    int pick;
    begin
      for (int n = 0; n < count; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 80 && gate_hi > gate_lo + 24'd1)
          r = 24'($urandom_range(gate_lo + 1, gate_hi - 1));
        else if (pick < 85) r = gate_lo;
        else if (pick < 90) r = gate_hi;
        else r = 24'($urandom);
        if ($urandom_range(0, 99) < 85 && beams_used > 0)
          idx = 7'($urandom_range(0, beams_used - 1));
        else
          idx = 7'($urandom);
        send_beam(r, 16'($urandom), idx, $urandom);
      end
    end
  endtask

  initial begin
    #4000000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    gate_lo = '0;
    gate_hi = 24'hFFFFFF;
    beams_used = 1;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Reset defaults: range gate edges, both intensity extremes, quadrant angles.
    send_beam(24'd1, 16'h0000, 7'd0, 32'd0);
    send_beam(24'hFFFFFE, 16'hFFFF, 7'd0, 32'd0);
    send_beam(24'd0, 16'h1234, 7'd0, 32'd16384);
    send_beam(24'hFFFFFF, 16'h4321, 7'd0, 32'd16384);
    send_beam(24'hFFFFFE, 16'hA5A5, 7'd1, 32'd0);
    send_beam(24'hFFFFFE, 16'h5A5A, 7'd127, 32'd0);
    send_beam(24'h800000, 16'h0001, 7'd0, 32'h00008000);
    send_beam(24'h7FFFFF, 16'h8000, 7'd0, 32'h7FFFFFFF);
    send_beam(24'h555555, 16'hFFFE, 7'd0, 32'h80000000);
    send_beam(24'hAAAAAA, 16'h7FFF, 7'd0, 32'h00002000);
    send_beam(24'h123456, 16'h00FF, 7'd0, 32'h12345678);
    send_beam(24'hFFFFFE, 16'hFF00, 7'd0, 32'hFFFFC000);

    set_mode(24'd0, 24'hFFFFFF, 16'h8000, 23'h7FFFFF, 8'd128, 1'b0);
    send_beam(24'hFFFFFE, 16'h0F0F, 7'd127, 32'hFFFFFFFF);
    send_beam(24'hFFFFFE, 16'hF0F0, 7'd0, 32'h00004000);
    random_beams(50);
    drain();
    random_beams(50);

    set_mode(24'd1000, 24'd200000, 16'h7FFF, 23'd25600, 8'd64, 1'b1);
    send_beam(24'd1000, 16'h0, 7'd0, 32'd0);
    send_beam(24'd200000, 16'h0, 7'd0, 32'd0);
    send_beam(24'd1001, 16'h1, 7'd63, 32'd0);
    send_beam(24'd199999, 16'h2, 7'd64, 32'd0);
    random_beams(90);

    set_mode(24'hFFFFFF, 24'd0, 16'h0, 23'd0, 8'd1, 1'b0);
    random_beams(20);

    set_mode(24'd0, 24'hFFFFFF, 16'h4000, 23'd1000, 8'd1, 1'b1);
    random_beams(80);

    set_mode(24'd500, 24'd10000000, 16'hF830, 23'd5000, 8'd255, 1'b1);
    random_beams(90);

    set_mode(24'd0, 24'hFFFFFF, 16'd1234, 23'd777, 8'd0, 1'b0);
    random_beams(20);

    set_mode(24'd0, 24'hFFFFFF, 16'hC000, 23'd65536, 8'd16, 1'b0);
    random_beams(60);

    set_mode(24'($urandom_range(0, 4095)), 24'hFFFFFF - 24'($urandom_range(0, 4095)),
             16'($urandom), 23'($urandom), 8'($urandom_range(2, 128)),
             1'($urandom_range(0, 1)));
    random_beams(100);

    drain();
    if (errors == 0 && pending == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

FILE: files.f
rtl/core/lbp_pkg.sv
rtl/core/lbp_cell.sv
rtl/core/lbp_scale.sv
rtl/core/lidar_beam_to_point.sv
verif/lidar_beam_to_point_checker.sv
verif/lidar_beam_to_point_test.sv
